[design/qvr_pkg.sv]
// Shared constants and types for the quaternion point rotation block.
package qvr_pkg;

  // Quaternion components are signed Q2.14
  localparam int unsigned QuatWidth     = 16;
  // Rotation matrix entries: Q6.28, wide enough for 2*(x*y - z*w) at full scale
  localparam int unsigned MatWidth      = 34;
  localparam int unsigned FracShift     = 28;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned NumRegs       = 4;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned CfgDataWidth  = QuatWidth;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ROT_REAL = 2'd0,
    REG_ROT_I    = 2'd1,
    REG_ROT_J    = 2'd2,
    REG_ROT_K    = 2'd3
  } cfg_reg_e;

  // 3x3 rotation matrix, [row][col]
  typedef logic [2:0][2:0][MatWidth-1:0] mat_t;

endpackage

[design/quaternion_vector_rotation.sv]
// Top level: streams 3D points through the rotation q * p * conj(q).
//
// Each point (signed Q16.16) is multiplied by the 3x3 matrix built from the
// rotation quaternion (signed Q2.14, not normalized, so the result scales by
// |q|^2), rounded half up and saturated to COORD_WIDTH bits; tuser flags a
// clamp. The datapath is a six-stage pipeline (input, partial products,
// entry products, two adder stages, round/saturate output register): one
// point is taken every cycle while the input is not held by a stall. A stall
// fills empty stages first, then backs up to the input. The matrix register
// is fed from products of the next quaternion value, so a point may follow a
// write in the very next cycle.
module quaternion_vector_rotation
  import qvr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  // input points
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata: point_x, point_y, point_z, zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // rotated points
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // tdata: rotated_x, rotated_y, rotated_z, zero pad
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // tuser: saturated
  output logic                    m_axis_tuser_o
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned DataW  = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned PadW   = DataW - 3 * CW;
  localparam int unsigned LoW    = CW / 2;
  localparam int unsigned HiW    = CW - LoW;
  localparam int unsigned LoPw   = MatWidth + LoW + 1;
  localparam int unsigned HiPw   = MatWidth + HiW;
  localparam int unsigned PrW    = MatWidth + CW;
  localparam int unsigned SumW   = PrW + 2;
  localparam int unsigned ShW    = SumW - FracShift;
  localparam int unsigned NStage = 6;
  localparam logic [SumW-1:0] RoundK = SumW'(1) << (FracShift - 1);

  // coefficient pipeline
  mat_t mat;

  qvr_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mat_o      (mat)
  );

  // stage valids and advance enables
  logic [NStage-1:0] v_q, v_d, en;
  logic [NStage-1:0] v_in;

  always_comb begin
    en[NStage-1] = !v_q[NStage-1] || m_axis_tready_i;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NStage-2:0], s_axis_tvalid_i};
    for (int k = 0; k < NStage; k++) begin
      v_d[k] = en[k] ? v_in[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NStage-1];

  // stage 1: input register
  logic [2:0][CW-1:0] pt_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pt_q <= s_axis_tdata_i[3*CW-1:0];
    end
  end

  // stage 2: split coordinate products, low half unsigned, high half signed
  logic signed [LoPw-1:0] pp_lo_q [3][3];
  logic signed [HiPw-1:0] pp_hi_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp_lo_q[r][c] <= $signed(mat[r][c]) * $signed({1'b0, pt_q[c][LoW-1:0]});
          pp_hi_q[r][c] <= $signed(mat[r][c]) * $signed(pt_q[c][CW-1:LoW]);
        end
      end
    end
  end

  // stage 3: full entry products
  logic signed [PrW-1:0] prod_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= (PrW'(pp_hi_q[r][c]) <<< LoW) + PrW'(pp_lo_q[r][c]);
        end
      end
    end
  end

  // stage 4: first partial row sum
  logic signed [SumW-1:0] s01_q [3];
  logic signed [PrW-1:0]  p2_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        s01_q[r] <= SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]);
        p2_q[r]  <= prod_q[r][2];
      end
    end
  end

  // stage 5: full row sum with rounding constant
  logic signed [SumW-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= s01_q[r] + SumW'(p2_q[r]) + $signed(RoundK);
      end
    end
  end

  // stage 6: shift, saturate, output register
  logic [ShW-1:0]       sh   [3];
  logic [ShW-CW:0]      top  [3];
  logic [2:0][CW-1:0]   res_d;
  logic [2:0]           clip;
  logic [2:0][CW-1:0]   res_q;
  logic                 sat_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r]   = sum_q[r][SumW-1:FracShift];
      top[r]  = sh[r][ShW-1:CW-1];
      clip[r] = !((&top[r]) || !(|top[r]));
      if (!clip[r]) begin
        res_d[r] = sh[r][CW-1:0];
      end else if (sh[r][ShW-1]) begin
        res_d[r] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res_d[r] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      res_q <= res_d;
      sat_q <= |clip;
    end
  end

  generate
    if (PadW > 0) begin : g_pad
      assign m_axis_tdata_o = {{PadW{1'b0}}, res_q};
    end else begin : g_nopad
      assign m_axis_tdata_o = res_q;
    end
  endgenerate

  assign m_axis_tuser_o = sat_q;

  // checks
  localparam logic [CW-1:0] MaxV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MinV = {1'b1, {(CW-1){1'b0}}};

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output register is empty");

  a_full_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken into a full stalled pipeline");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (res_q[0] == MaxV || res_q[0] == MinV || res_q[1] == MaxV ||
       res_q[1] == MinV || res_q[2] == MaxV || res_q[2] == MinV))
    else $error("saturation flag without a clamped coordinate");

endmodule

[design/qvr_coef.sv]
// Rotation quaternion registers and the two-stage matrix coefficient pipeline.
module qvr_coef
  import qvr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output mat_t                    mat_o
);

  localparam int unsigned PrW = 2 * QuatWidth;
  localparam logic [QuatWidth-1:0] RealRst = QuatWidth'(1 << (QuatWidth - 2));
  localparam logic [PrW-1:0]       SqRst   = PrW'(1 << (2 * QuatWidth - 4));
  localparam logic [MatWidth-1:0]  DiagRst = MatWidth'(1 << FracShift);
  localparam logic [MatWidth-1:0]  ZeroEnt = '0;
  // identity matrix, entry [2][2] in the top bits
  localparam mat_t                 MatRst  = {DiagRst, ZeroEnt, ZeroEnt,
                                              ZeroEnt, DiagRst, ZeroEnt,
                                              ZeroEnt, ZeroEnt, DiagRst};

  logic [QuatWidth-1:0] qa_q, qb_q, qc_q, qd_q;
  logic [QuatWidth-1:0] qa_d, qb_d, qc_d, qd_d;

  // next value of the quaternion registers
  always_comb begin
    qa_d = qa_q;
    qb_d = qb_q;
    qc_d = qc_q;
    qd_d = qd_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROT_REAL: qa_d = cfg_data_i;
        REG_ROT_I:    qb_d = cfg_data_i;
        REG_ROT_J:    qc_d = cfg_data_i;
        REG_ROT_K:    qd_d = cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= RealRst;
      qb_q <= '0;
      qc_q <= '0;
      qd_q <= '0;
    end else begin
      qa_q <= qa_d;
      qb_q <= qb_d;
      qc_q <= qc_d;
      qd_q <= qd_d;
    end
  end

  // stage 1: the ten pairwise products, taken from the next register value
  // so the matrix is ready in the cycle after the write lands
  logic signed [PrW-1:0] aa_q, bb_q, cc_q, dd_q, ab_q, ac_q, ad_q, bc_q, bd_q, cd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aa_q <= SqRst;
      bb_q <= '0;
      cc_q <= '0;
      dd_q <= '0;
      ab_q <= '0;
      ac_q <= '0;
      ad_q <= '0;
      bc_q <= '0;
      bd_q <= '0;
      cd_q <= '0;
    end else begin
      aa_q <= $signed(qa_d) * $signed(qa_d);
      bb_q <= $signed(qb_d) * $signed(qb_d);
      cc_q <= $signed(qc_d) * $signed(qc_d);
      dd_q <= $signed(qd_d) * $signed(qd_d);
      ab_q <= $signed(qa_d) * $signed(qb_d);
      ac_q <= $signed(qa_d) * $signed(qc_d);
      ad_q <= $signed(qa_d) * $signed(qd_d);
      bc_q <= $signed(qb_d) * $signed(qc_d);
      bd_q <= $signed(qb_d) * $signed(qd_d);
      cd_q <= $signed(qc_d) * $signed(qd_d);
    end
  end

  // stage 2: matrix entries
  logic signed [MatWidth-1:0] aa_w, bb_w, cc_w, dd_w, ab_w, ac_w, ad_w, bc_w, bd_w, cd_w;
  mat_t mat_d, mat_q;

  always_comb begin
    aa_w = MatWidth'(aa_q);
    bb_w = MatWidth'(bb_q);
    cc_w = MatWidth'(cc_q);
    dd_w = MatWidth'(dd_q);
    ab_w = MatWidth'(ab_q);
    ac_w = MatWidth'(ac_q);
    ad_w = MatWidth'(ad_q);
    bc_w = MatWidth'(bc_q);
    bd_w = MatWidth'(bd_q);
    cd_w = MatWidth'(cd_q);
    mat_d[0][0] = aa_w + bb_w - cc_w - dd_w;
    mat_d[0][1] = (bc_w - ad_w) <<< 1;
    mat_d[0][2] = (bd_w + ac_w) <<< 1;
    mat_d[1][0] = (bc_w + ad_w) <<< 1;
    mat_d[1][1] = aa_w - bb_w + cc_w - dd_w;
    mat_d[1][2] = (cd_w - ab_w) <<< 1;
    mat_d[2][0] = (bd_w - ac_w) <<< 1;
    mat_d[2][1] = (cd_w + ab_w) <<< 1;
    mat_d[2][2] = aa_w - bb_w - cc_w + dd_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MatRst;
    end else begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule
